// File: src/ipv4_header_validate_parse_macros.svh
// ----------------------------------------------------------------------------
// ipv4 header parser assertion macros
// concurrent assertion wrappers on clk, with and without reset masking
// ----------------------------------------------------------------------------
`ifndef IPV4_HEADER_VALIDATE_PARSE_MACROS_SVH
`define IPV4_HEADER_VALIDATE_PARSE_MACROS_SVH

// checked only while out of reset
`define IHV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define IHV_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/ipv4hv_pkg.sv
// ----------------------------------------------------------------------------
// ipv4hv_pkg
// shared types and constants of the ipv4 header validate/parse block
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4hv_pkg;

	localparam int unsigned HDR_BYTES = 20;
	localparam int unsigned POS_W     = $clog2(HDR_BYTES);

	localparam logic [7:0]  VERSION_IHL       = 8'h45;
	localparam logic [7:0]  DSCP_ZERO         = 8'h00;
	localparam logic [15:0] FLAG_DF_MASK      = 16'h4000;
	localparam logic [15:0] FLAG_OTHER_MASK   = 16'hBFFF;
	localparam logic [15:0] SUM_GOOD          = 16'hFFFF;
	localparam logic [15:0] COUNT_MAX         = 16'hFFFF;
	localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd65515;

	typedef enum logic [3:0] {
		VERDICT_OK        = 4'd0,
		VERDICT_SHORT     = 4'd1,
		VERDICT_VERSION   = 4'd2,
		VERDICT_DSCP      = 4'd3,
		VERDICT_LENGTH    = 4'd4,
		VERDICT_FRAGMENT  = 4'd5,
		VERDICT_TTL_ZERO  = 4'd6,
		VERDICT_CHECKSUM  = 4'd7,
		VERDICT_TOO_LARGE = 4'd8
	} verdict_t;

	// packet state as it stands once the current byte is taken in
	typedef struct packed {
		logic [HDR_BYTES-1:0][7:0] hdr;
		logic [15:0]               count;
		logic                      ovf;
		logic [15:0]               sum;
	} pkt_view_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [31:0] src;
		logic [31:0] dst;
		logic [7:0]  proto;
		logic [7:0]  ttl;
		logic [15:0] ident;
		logic        df;
		logic [15:0] payload;
	} result_t;

endpackage

`default_nettype wire

// File: src/ipv4_header_validate_parse.sv
// ----------------------------------------------------------------------------
// ipv4_header_validate_parse
// byte-wide ipv4 header checker and field parser, top level
// ----------------------------------------------------------------------------
// A packet enters one byte per transaction, with last_byte on its final byte,
// and one byte can be taken every cycle unless the input stalls. Each byte is
// held in an input register. The edge that moves it on updates the count,
// header store and checksum sum and, on a final byte, loads the verdict and
// header fields into the result register and raises result_valid; the
// result can be taken at the next edge. The input stalls only when a final
// byte finds the result register still holding an untaken result.
// max_payload is written through cfg_we/cfg_wdata and resets to 65515. The
// user writes it only while the block is idle; the block does not enforce it.
`default_nettype none

`include "ipv4_header_validate_parse_macros.svh"

module ipv4_header_validate_parse (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [3:0]       verdict,
	output logic [31:0]      source_address,
	output logic [31:0]      destination_address,
	output logic [7:0]       protocol_number,
	output logic [7:0]       hop_limit,
	output logic [15:0]      ident,
	output logic             no_fragment,
	output logic [15:0]      payload_length
);
	import ipv4hv_pkg::*;

	logic [15:0] max_pl_q;
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        adv_s1;
	pkt_view_t   view;
	result_t     res;
	result_t     result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pl_q <= MAX_PAYLOAD_RESET;
		end else if (cfg_we) begin
			max_pl_q <= cfg_wdata;
		end
	end

	// non-final bytes never wait on the result side
	assign adv_s1     = valid_s1 && (!last_s1 || !result_valid || !result_stall);
	assign byte_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	ipv4hv_accum u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (adv_s1),
		.data_s1 (data_s1),
		.last_s1 (last_s1),
		.view    (view)
	);

	ipv4hv_check u_check (
		.view        (view),
		.max_payload (max_pl_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			result_q <= res;
		end
	end

	assign verdict             = result_q.verdict;
	assign source_address      = result_q.src;
	assign destination_address = result_q.dst;
	assign protocol_number     = result_q.proto;
	assign hop_limit           = result_q.ttl;
	assign ident               = result_q.ident;
	assign no_fragment         = result_q.df;
	assign payload_length      = result_q.payload;

	`IHV_ASSERT_ALWAYS(a_idle_in_reset, !arst_n |-> !result_valid, "result valid during reset")
	`IHV_ASSERT(a_result_from_last, $rose(result_valid) |-> $past(adv_s1 && last_s1),
		"result appeared without a final byte")
	`IHV_ASSERT(a_stall_cause,
		byte_stall |-> (valid_s1 && last_s1 && result_valid && result_stall),
		"input stalled without a blocked final byte")
	`IHV_ASSERT(a_payload_only_ok,
		(result_valid && verdict != VERDICT_OK) |-> payload_length == 16'd0,
		"payload length given on a failed verdict")

endmodule

`default_nettype wire

// File: src/ipv4hv_accum.sv
// ----------------------------------------------------------------------------
// ipv4hv_accum
// byte counter, header byte store and running ones'-complement header sum
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hv_accum (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  advance,
	input  wire logic [7:0]            data_s1,
	input  wire logic                  last_s1,
	output ipv4hv_pkg::pkt_view_t      view
);
	import ipv4hv_pkg::*;

	logic [15:0]      count_q;
	logic             ovf_q;
	logic [15:0]      sum_q;
	logic [7:0]       high_q;
	logic [7:0]       hdr_q [HDR_BYTES];

	logic             in_hdr;
	logic [POS_W-1:0] pos;
	logic [16:0]      sum_wide;
	logic [15:0]      sum_fold;
	logic [15:0]      sum_nxt;
	logic [7:0]       high_nxt;
	logic             at_max;

	assign in_hdr   = count_q < 16'(HDR_BYTES);
	assign pos      = count_q[POS_W-1:0];
	assign at_max   = count_q == COUNT_MAX;
	assign sum_wide = {1'b0, sum_q} + {1'b0, high_q, data_s1};
	// end-around carry
	assign sum_fold = sum_wide[15:0] + {15'd0, sum_wide[16]};

	always_comb begin
		sum_nxt  = sum_q;
		high_nxt = high_q;
		if (in_hdr) begin
			if (!pos[0]) begin
				high_nxt = data_s1;
			end else begin
				sum_nxt = sum_fold;
			end
		end
		for (int i = 0; i < HDR_BYTES; i++) begin
			view.hdr[i] = (in_hdr && pos == POS_W'(i)) ? data_s1 : hdr_q[i];
		end
		view.count = at_max ? count_q : count_q + 16'd1;
		view.ovf   = ovf_q | at_max;
		view.sum   = sum_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			sum_q   <= '0;
			high_q  <= '0;
		end else if (advance) begin
			if (last_s1) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
				sum_q   <= '0;
				high_q  <= '0;
			end else begin
				count_q <= view.count;
				ovf_q   <= view.ovf;
				sum_q   <= sum_nxt;
				high_q  <= high_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_hdr) begin
			hdr_q[pos] <= data_s1;
		end
	end

endmodule

`default_nettype wire

// File: src/ipv4hv_check.sv
// ----------------------------------------------------------------------------
// ipv4hv_check
// header checks in priority order and field extraction for the final byte
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hv_check (
	input  wire ipv4hv_pkg::pkt_view_t view,
	input  wire logic [15:0]           max_payload,
	output ipv4hv_pkg::result_t        res
);
	import ipv4hv_pkg::*;

	logic        short_pkt;
	logic [15:0] total_len;
	logic [15:0] flags;
	logic [15:0] payload;
	verdict_t    verdict;

	assign short_pkt = !view.ovf && (view.count < 16'(HDR_BYTES));
	assign total_len = {view.hdr[2], view.hdr[3]};
	assign flags     = {view.hdr[6], view.hdr[7]};
	assign payload   = view.count - 16'(HDR_BYTES);

	always_comb begin
		if (view.hdr[0] != VERSION_IHL) begin
			verdict = VERDICT_VERSION;
		end else if (view.hdr[1] != DSCP_ZERO) begin
			verdict = VERDICT_DSCP;
		end else if (view.ovf || total_len != view.count) begin
			verdict = VERDICT_LENGTH;
		end else if ((flags & FLAG_OTHER_MASK) != 16'd0) begin
			verdict = VERDICT_FRAGMENT;
		end else if (view.hdr[8] == 8'd0) begin
			verdict = VERDICT_TTL_ZERO;
		end else if (view.sum != SUM_GOOD) begin
			verdict = VERDICT_CHECKSUM;
		end else if (payload > max_payload) begin
			verdict = VERDICT_TOO_LARGE;
		end else begin
			verdict = VERDICT_OK;
		end

		if (short_pkt) begin
			res         = '0;
			res.verdict = VERDICT_SHORT;
		end else begin
			res.verdict = verdict;
			res.src     = {view.hdr[12], view.hdr[13], view.hdr[14], view.hdr[15]};
			res.dst     = {view.hdr[16], view.hdr[17], view.hdr[18], view.hdr[19]};
			res.proto   = view.hdr[9];
			res.ttl     = view.hdr[8];
			res.ident   = {view.hdr[4], view.hdr[5]};
			res.df      = (flags & FLAG_DF_MASK) != 16'd0;
			res.payload = (verdict == VERDICT_OK) ? payload : 16'd0;
		end
	end

endmodule

`default_nettype wire
